// ===== src/lksm_pkg.sv =====
// ----------------------------------------------------------------------------
// lksm_pkg
// Shared constants and types for the LRU key-to-slot mapper.
// ----------------------------------------------------------------------------
package lksm_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_W   = 32;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic resolve;
    logic commit;
  } cmd_t;

endpackage

// ===== src/lksm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lksm_ctrl
// Sequencer for the mapper: load the key, resolve the lookup, commit the update.
// ----------------------------------------------------------------------------
module lksm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output lksm_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r == ST_CMP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load    = accept;
  assign cmd.resolve = (state_r == ST_CMP);
  assign cmd.commit  = (state_r == ST_UPD);

endmodule

// ===== src/lksm_datapath.sv =====
// ----------------------------------------------------------------------------
// lksm_datapath
// Key table, recency ranks, counters and result registers of the mapper.
// ----------------------------------------------------------------------------
module lksm_datapath #(
  parameter int ENTRIES  = lksm_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lksm_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lksm_pkg::cmd_t                cmd,
  input  logic [lksm_pkg::KEY_W-1:0]    in_key,
  input  logic                          cfg_valid,
  input  logic [lksm_pkg::CAP_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic [$clog2(ENTRIES)-1:0]    out_slot_index,
  output logic                          out_is_new,
  output logic                          out_evicted,
  output logic [lksm_pkg::COUNT_W-1:0]  out_lookup_total,
  output logic [lksm_pkg::COUNT_W-1:0]  out_eviction_total
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int USED_W = $clog2(ENTRIES + 1);
  localparam int KW     = (KEY_BITS < lksm_pkg::KEY_W) ? KEY_BITS : lksm_pkg::KEY_W;

  logic [KW-1:0]                  keys_r [ENTRIES];
  logic [IDX_W-1:0]               rank_r [ENTRIES];
  logic [USED_W-1:0]              used_r;
  logic [KW-1:0]                  key_r;
  logic [lksm_pkg::CAP_W-1:0]     cap_r;
  logic                           hit_r;
  logic                           evict_r;
  logic [IDX_W-1:0]               slot_r;
  logic [IDX_W-1:0]               touch_rank_r;
  logic [lksm_pkg::COUNT_W-1:0]   lookups_r;
  logic [lksm_pkg::COUNT_W-1:0]   evicts_r;

  logic                           out_valid_r;
  logic [IDX_W-1:0]               out_slot_r;
  logic                           out_is_new_r;
  logic                           out_evicted_r;
  logic [lksm_pkg::COUNT_W-1:0]   out_lookups_r;
  logic [lksm_pkg::COUNT_W-1:0]   out_evicts_r;

  logic [ENTRIES-1:0]             valid;
  logic [ENTRIES-1:0]             match;
  logic [ENTRIES-1:0]             lru;
  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               lru_idx;
  logic [IDX_W-1:0]               match_rank;
  logic                           hit;
  logic                           full;
  logic [31:0]                    cap_w;
  logic [31:0]                    used_w;

  // Valid keys are unique and valid ranks form a permutation, so the match
  // and LRU vectors have at most one bit set and encode by plain OR.
  always_comb begin
    hit_idx    = '0;
    lru_idx    = '0;
    match_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = (32'(i) < 32'(used_r));
      match[i] = valid[i] && (keys_r[i] == key_r);
      lru[i]   = valid[i] && (rank_r[i] == '0);
      if (match[i]) begin
        hit_idx    = hit_idx | IDX_W'(i);
        match_rank = match_rank | rank_r[i];
      end
      if (lru[i]) lru_idx = lru_idx | IDX_W'(i);
    end
  end

  assign hit    = |match;
  assign cap_w  = 32'(cap_r);
  assign used_w = 32'(used_r);

  always_comb begin
    if (cap_w == 32'd0) begin
      full = (used_w >= 32'd1);
    end else if (cap_w > 32'(ENTRIES)) begin
      full = (used_w >= 32'(ENTRIES));
    end else begin
      full = (used_w >= cap_w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) key_r <= in_key[KW-1:0];
    if (cmd.resolve) begin
      hit_r        <= hit;
      evict_r      <= !hit && full;
      slot_r       <= hit ? hit_idx : (full ? lru_idx : used_r[IDX_W-1:0]);
      touch_rank_r <= hit ? match_rank : '0;
    end
    if (cmd.commit) begin
      if (!hit_r) keys_r[slot_r] <= key_r;
      if (hit_r || evict_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_r == IDX_W'(i)) begin
            rank_r[i] <= IDX_W'(used_r - 1'b1);
          end else if (valid[i] && (rank_r[i] > touch_rank_r)) begin
            rank_r[i] <= rank_r[i] - 1'b1;
          end
        end
      end else begin
        rank_r[slot_r] <= IDX_W'(used_r);
      end
      out_slot_r    <= slot_r;
      out_is_new_r  <= !hit_r;
      out_evicted_r <= evict_r;
      out_lookups_r <= lookups_r + 1'b1;
      out_evicts_r  <= evicts_r + lksm_pkg::COUNT_W'(evict_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cap_r       <= lksm_pkg::CAP_RESET;
      lookups_r   <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cfg_valid) cap_r <= cfg_data;
      if (cmd.commit) begin
        lookups_r <= lookups_r + 1'b1;
        if (evict_r) evicts_r <= evicts_r + 1'b1;
        if (!hit_r && !evict_r) used_r <= used_r + 1'b1;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot_index     = out_slot_r;
  assign out_is_new         = out_is_new_r;
  assign out_evicted        = out_evicted_r;
  assign out_lookup_total   = out_lookups_r;
  assign out_eviction_total = out_evicts_r;

endmodule

// ===== src/lru_key_to_slot_mapper.sv =====
// ----------------------------------------------------------------------------
// lru_key_to_slot_mapper
// Fully associative LRU table that maps keys to slot numbers.
//
// A transaction is taken at a rising edge with start high and busy low; the
// key is on in_key. The result appears on the out_ ports after the compare
// and update states, marked by out_valid for exactly one cycle; the receiver
// cannot stall it. Each transaction passes through the parallel key compare
// and LRU search, then the recency rank update; a new transaction can be
// taken during the rank update. busy is high only in the compare cycle, so
// start may be held high.
// The capacity register is written through cfg_valid and cfg_data; cfg_ready
// is always high. Write it only while no transaction is in flight.
// Reset clears the slot count and both counters and sets capacity to 16.
// The key and rank storage needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module lru_key_to_slot_mapper #(
  parameter int ENTRIES  = lksm_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lksm_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lksm_pkg::KEY_W-1:0]    in_key,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lksm_pkg::CAP_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic [$clog2(ENTRIES)-1:0]    out_slot_index,
  output logic                          out_is_new,
  output logic                          out_evicted,
  output logic [lksm_pkg::COUNT_W-1:0]  out_lookup_total,
  output logic [lksm_pkg::COUNT_W-1:0]  out_eviction_total
);

  lksm_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  lksm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lksm_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_key             (in_key),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_slot_index     (out_slot_index),
    .out_is_new         (out_is_new),
    .out_evicted        (out_evicted),
    .out_lookup_total   (out_lookup_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule

// ===== dv/lru_key_to_slot_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_to_slot_mapper_tb
// Self-checking testbench for the LRU key-to-slot mapper. A scoreboard class
// keeps its own copy of the key table and recency order, predicts the slot,
// flags and counters of every accepted lookup, and compares each strobed
// result against the oldest prediction. Directed lookups cover free-room
// allocation, hits and evictions. Random phases then run under several
// capacity settings, including zero, oversized and lowered values, with
// varying start idling.
// ----------------------------------------------------------------------------
module lru_key_to_slot_mapper_tb;

  localparam int SLOT_W = $clog2(lksm_pkg::ENTRIES_DEF);
  localparam int POOL_MAX = 40;
  localparam int PHASES = 10;
  localparam int PHASE_LOOKUPS = 170;
  localparam int EXP_DEPTH = 8;
  localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

  typedef struct packed {
    logic [SLOT_W-1:0]            slot_index;
    logic                         is_new;
    logic                         evicted;
    logic [lksm_pkg::COUNT_W-1:0] lookup_total;
    logic [lksm_pkg::COUNT_W-1:0] eviction_total;
  } slot_result_t;

  class slot_map_scoreboard;
    logic [lksm_pkg::KEY_W-1:0]   slot_key[lksm_pkg::ENTRIES_DEF];
    bit [SLOT_W-1:0]              rank[lksm_pkg::ENTRIES_DEF];
    int unsigned                  used;
    bit [lksm_pkg::COUNT_W-1:0]   lookups;
    bit [lksm_pkg::COUNT_W-1:0]   evictions;
    bit [lksm_pkg::CAP_W-1:0]     capacity;
    slot_result_t                 expected_mem[EXP_DEPTH];
    bit [EXP_PTR_W-1:0]           wr_ptr;
    bit [EXP_PTR_W-1:0]           rd_ptr;
    int                           expected_n;
    int                           errors;

    function new();
      used = 0;
      lookups = '0;
      evictions = '0;
      capacity = lksm_pkg::CAP_RESET;
      wr_ptr = '0;
      rd_ptr = '0;
      expected_n = 0;
      errors = 0;
    endfunction

    function int unsigned limit();
      if (capacity == 0) return 1;
      if (capacity > lksm_pkg::ENTRIES_DEF) return lksm_pkg::ENTRIES_DEF;
      return capacity;
    endfunction

    function int pending();
      return expected_n;
    endfunction

    // Makes slot s the most recently used; newer entries move down one place.
    function void promote(int unsigned s);
      bit [SLOT_W-1:0] r;
      r = rank[s];
      for (int i = 0; i < used; i++) begin
        if (rank[i] > r) rank[i]--;
      end
      rank[s] = SLOT_W'(used - 1);
    endfunction

    function void note_lookup(logic [lksm_pkg::KEY_W-1:0] key);
      slot_result_t want;
      int unsigned  s;
      bit           hit;
      want = '0;
      s = 0;
      hit = 0;
      lookups++;
      for (int i = 0; i < used; i++) begin
        if (!hit && slot_key[i] == key) begin
          s = i;
          hit = 1;
        end
      end
      if (hit) begin
        promote(s);
      end else if (used < limit()) begin
        s = used;
        slot_key[s] = key;
        rank[s] = SLOT_W'(used);
        used++;
      end else begin
        for (int i = 0; i < used; i++) begin
          if (rank[i] == 0) s = i;
        end
        evictions++;
        want.evicted = 1'b1;
        slot_key[s] = key;
        promote(s);
      end
      want.slot_index = s[SLOT_W-1:0];
      want.is_new = !hit;
      want.lookup_total = lookups;
      want.eviction_total = evictions;
      if (expected_n == EXP_DEPTH) begin
        $error("Too many lookups pending");
        errors++;
        return;
      end
      expected_mem[wr_ptr] = want;
      wr_ptr++;
      expected_n++;
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (expected_n == 0) begin
        $error("Result with no lookup pending: slot_index %0d", got.slot_index);
        errors++;
        return;
      end
      want = expected_mem[rd_ptr];
      rd_ptr++;
      expected_n--;
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.is_new !== want.is_new) begin
        $error("is_new: expected %0b, actual %0b", want.is_new, got.is_new);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0b, actual %0b", want.evicted, got.evicted);
        errors++;
      end
      if (got.lookup_total !== want.lookup_total) begin
        $error("lookup_total: expected %0d, actual %0d", want.lookup_total,
               got.lookup_total);
        errors++;
      end
      if (got.eviction_total !== want.eviction_total) begin
        $error("eviction_total: expected %0d, actual %0d", want.eviction_total,
               got.eviction_total);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [lksm_pkg::KEY_W-1:0]   in_key = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lksm_pkg::CAP_W-1:0]   cfg_data = lksm_pkg::CAP_RESET;
  logic                         out_valid;
  logic [SLOT_W-1:0]            out_slot_index;
  logic                         out_is_new;
  logic                         out_evicted;
  logic [lksm_pkg::COUNT_W-1:0] out_lookup_total;
  logic [lksm_pkg::COUNT_W-1:0] out_eviction_total;

  slot_map_scoreboard           board = new();
  slot_result_t                 seen;
  int                           idle_pct = 0;
  logic [lksm_pkg::KEY_W-1:0]   pool[POOL_MAX];
  int                           pool_n = 1;

  lru_key_to_slot_mapper u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_key             (in_key),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_slot_index     (out_slot_index),
    .out_is_new         (out_is_new),
    .out_evicted        (out_evicted),
    .out_lookup_total   (out_lookup_total),
    .out_eviction_total (out_eviction_total)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen.slot_index = out_slot_index;
      seen.is_new = out_is_new;
      seen.evicted = out_evicted;
      seen.lookup_total = out_lookup_total;
      seen.eviction_total = out_eviction_total;
      board.check_result(seen);
    end
  end

  task automatic pause_cycle();
    @(negedge clk);
    start <= 1'b0;
    in_key <= $urandom();
  endtask

  task automatic lookup(input logic [lksm_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) pause_cycle();
    @(negedge clk);
    start <= 1'b1;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_lookup(key);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lksm_pkg::CAP_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.capacity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= lksm_pkg::CAP_W'($urandom());
  endtask

  function automatic logic [lksm_pkg::KEY_W-1:0] pick_key();
    int r;
    int idx;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(lksm_pkg::KEY_W - 1);
    if (r < 80) return pool[$urandom_range(pool_n - 1)];
    if (r < 90) begin
      idx = $urandom_range(pool_n - 1);
      pool[idx] = $urandom();
      return pool[idx];
    end
    if (r < 96) return $urandom();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h1 << k;
      default: return ~(32'h1 << k);
    endcase
  endfunction

  initial begin
    logic [lksm_pkg::CAP_W-1:0] caps[PHASES];
    caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd2, 5'd12, 5'd5};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 13;
    write_capacity(5'd2);
    lookup('0);
    lookup('1);
    lookup('0);
    lookup(32'hA5A5_5A5A);
    lookup('1);
    write_capacity(5'd16);
    for (int i = 0; i < 14; i++) begin
      lookup((i % 2) ? ~(32'h1 << (2 * i)) : 32'h1 << (2 * i + 1));
    end
    lookup(32'h1234_5678);
    lookup(32'h0000_0002);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      idle_pct = (p < 4) ? 13 : (p < 7) ? 79 : 0;
      pool_n = $urandom_range(1, 2 * board.limit() + 4);
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom();
      for (int n = 0; n < PHASE_LOOKUPS; n++) begin
        if (p == 0 && n == PHASE_LOOKUPS / 2) drain();
        lookup(pick_key());
      end
    end

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
